### rtl/core/length_prefixed_packet_deframer_unit_macros.svh
// ----------------------------------------------------------------------------
// Length-prefixed packet deframer assertion macros
// Shared concurrent assertion forms for the deframer checker.
// ----------------------------------------------------------------------------
`ifndef LENGTH_PREFIXED_PACKET_DEFRAMER_UNIT_MACROS_SVH
`define LENGTH_PREFIXED_PACKET_DEFRAMER_UNIT_MACROS_SVH

// Property checked on every clock edge outside of reset.
`define LPD_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Property checked on every clock edge, reset included.
`define LPD_ASSERT_ALWAYS(name, prop, msg) \
  name: assert property (@(posedge clk) prop) else $error(msg);

`endif

### rtl/core/lpd_pkg.sv
// ----------------------------------------------------------------------------
// Length-prefixed packet deframer package
// Command codes, register indexes, reset values and shared structs.
// ----------------------------------------------------------------------------
`default_nettype none

package lpd_pkg;

  // Input commands.
  localparam logic [1:0] OP_DATA  = 2'd0;
  localparam logic [1:0] OP_FLUSH = 2'd1;
  localparam logic [1:0] OP_CLEAR = 2'd2;

  // Configuration register indexes.
  localparam logic CFG_HEADER_BYTES  = 1'b0;
  localparam logic CFG_LENGTH_OFFSET = 1'b1;

  localparam logic [6:0] HEADER_BYTES_RESET = 7'd4;
  localparam logic [5:0] LENGTH_OFFSET_RESET = 6'd0;
  localparam logic [6:0] HEADER_BYTES_MIN = 7'd2;
  localparam logic [6:0] HEADER_BYTES_MAX = 7'd64;

  localparam int MAX_PACKET_BYTES_DEFAULT = 8192;

  typedef struct packed {
    logic [15:0] bytes_seen;
    logic [15:0] packet_length;
    logic [7:0]  length_low_byte;
    logic        length_known;
  } state_t;

  typedef struct packed {
    logic [7:0]  out_byte;
    logic        byte_valid;
    logic        first_of_packet;
    logic        last_of_packet;
    logic        ended_by_flush;
    logic        length_error;
    logic [15:0] dropped_bytes;
  } result_t;

endpackage

`default_nettype wire

### rtl/core/length_prefixed_packet_deframer_unit.sv
// ----------------------------------------------------------------------------
// Length-prefixed packet deframer
// Marks packet boundaries in a byte stream using an in-header length field.
// ----------------------------------------------------------------------------
// The unit takes one transfer per clock on the input channel while the
// result channel does not stall, and returns exactly one result transfer
// for each, in order. A transfer enters an input register; the next-state
// logic then updates the packet tracking state and loads the result
// register once that register is free or being emptied, so the sustained
// rate without backpressure is one transfer per cycle. That rate rests on
// the update of the byte counter and length registers, which every
// transfer reads and writes.
// Backpressure on the result channel stalls the input register, and the
// input is still taken while a finished result waits as long as the input
// register is empty. The header size and the offset of the 16-bit
// little-endian length field are written through the configuration port and
// must only change while the unit is idle. Declared lengths below the header
// size are raised to it and lengths above MAX_PACKET_BYTES are clamped; both
// cases set length_error on the byte that completes the header. There is no
// memory and no start-up sweep: the unit is ready right after reset.
// ----------------------------------------------------------------------------
`default_nettype none

module length_prefixed_packet_deframer_unit import lpd_pkg::*; #(
  parameter int MAX_PACKET_BYTES = MAX_PACKET_BYTES_DEFAULT
) (
  input  wire logic        clk,
  input  wire logic        rst,
  // Configuration port.
  input  wire logic        cfg_write,
  input  wire logic        cfg_index,
  input  wire logic [6:0]  cfg_data,
  // Input channel.
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [1:0]  op,
  input  wire logic [7:0]  data_byte,
  // Result channel.
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [7:0]       out_byte,
  output logic             byte_valid,
  output logic             first_of_packet,
  output logic             last_of_packet,
  output logic             ended_by_flush,
  output logic             length_error,
  output logic [15:0]      dropped_bytes
);

  logic [6:0] header_bytes;
  logic [5:0] length_field_offset;

  // Input register.
  logic       s1_valid;
  logic [1:0] s1_op;
  logic [7:0] s1_byte;

  // Packet tracking state.
  state_t  state;
  state_t  state_next;
  result_t res_next;

  logic advance;

  // The input register moves on when the result register is free or is
  // being emptied in this cycle.
  assign advance  = s1_valid && (!out_valid || out_ready);
  assign in_ready = !s1_valid || advance;

  lpd_frame_logic #(
    .MAX_PACKET_BYTES(MAX_PACKET_BYTES)
  ) u_frame (
    .header_bytes        (header_bytes),
    .length_field_offset (length_field_offset),
    .op                  (s1_op),
    .data_byte           (s1_byte),
    .state_cur           (state),
    .state_next          (state_next),
    .res                 (res_next)
  );

  // Control state, configuration and tracking state.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid            <= 1'b0;
      out_valid           <= 1'b0;
      state               <= '0;
      header_bytes        <= HEADER_BYTES_RESET;
      length_field_offset <= LENGTH_OFFSET_RESET;
    end else begin
      if (cfg_write) begin
        case (cfg_index)
          CFG_HEADER_BYTES:  header_bytes        <= cfg_data;
          CFG_LENGTH_OFFSET: length_field_offset <= cfg_data[5:0];
          default: begin
          end
        endcase
      end
      if (in_ready) begin
        s1_valid <= in_valid;
      end
      if (advance) begin
        out_valid <= 1'b1;
        state     <= state_next;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Payload registers carry no reset.
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_op   <= op;
      s1_byte <= data_byte;
    end
    if (advance) begin
      out_byte        <= res_next.out_byte;
      byte_valid      <= res_next.byte_valid;
      first_of_packet <= res_next.first_of_packet;
      last_of_packet  <= res_next.last_of_packet;
      ended_by_flush  <= res_next.ended_by_flush;
      length_error    <= res_next.length_error;
      dropped_bytes   <= res_next.dropped_bytes;
    end
  end

endmodule

`default_nettype wire

### rtl/core/lpd_frame_logic.sv
// ----------------------------------------------------------------------------
// Deframer next-state logic
// Computes the result and the next tracking state for one command.
// ----------------------------------------------------------------------------
`default_nettype none

module lpd_frame_logic import lpd_pkg::*; #(
  parameter int MAX_PACKET_BYTES = MAX_PACKET_BYTES_DEFAULT
) (
  input  wire logic [6:0] header_bytes,
  input  wire logic [5:0] length_field_offset,
  input  wire logic [1:0] op,
  input  wire logic [7:0] data_byte,
  input  wire state_t     state_cur,
  output state_t          state_next,
  output result_t         res
);

  localparam logic [15:0] MAX_LEN = 16'(MAX_PACKET_BYTES);

  logic [6:0]  hdr;
  logic [15:0] hdr16;
  logic [15:0] off16;
  logic [15:0] idx;
  logic [15:0] bs;
  logic        start;
  logic        lk0;
  logic [7:0]  llb0;
  logic [7:0]  llb1;
  logic [15:0] pl0;
  logic [15:0] pl1;
  logic [15:0] pl2;
  logic [15:0] raw;
  logic [15:0] raw_fix;
  logic        range_err;
  logic        take_len;
  logic        lk2;
  logic        done;

  // Header size is used saturated to its legal range.
  always_comb begin
    if (header_bytes < HEADER_BYTES_MIN) begin
      hdr = HEADER_BYTES_MIN;
    end else if (header_bytes > HEADER_BYTES_MAX) begin
      hdr = HEADER_BYTES_MAX;
    end else begin
      hdr = header_bytes;
    end
  end

  always_comb begin
    hdr16 = {9'd0, hdr};
    off16 = {10'd0, length_field_offset};
    idx   = state_cur.bytes_seen;
    bs    = idx + 16'd1;
    start = (idx == 16'd0);
    lk0   = start ? 1'b0  : state_cur.length_known;
    llb0  = start ? 8'd0  : state_cur.length_low_byte;
    pl0   = start ? 16'd0 : state_cur.packet_length;

    // Capture the length field bytes while the length is still unknown.
    llb1 = llb0;
    pl1  = pl0;
    if (!lk0) begin
      if (idx == off16) begin
        llb1 = data_byte;
      end else if (idx == off16 + 16'd1) begin
        pl1 = {data_byte, llb0};
      end
    end

    // Bytes of the field that fall outside the header read as zero.
    if ({1'b0, length_field_offset} + 7'd1 < hdr) begin
      raw = pl1;
    end else if ({1'b0, length_field_offset} < hdr) begin
      raw = {8'd0, llb1};
    end else begin
      raw = 16'd0;
    end

    range_err = 1'b0;
    raw_fix   = raw;
    if (raw < hdr16) begin
      raw_fix   = hdr16;
      range_err = 1'b1;
    end else if (raw > MAX_LEN) begin
      raw_fix   = MAX_LEN;
      range_err = 1'b1;
    end

    take_len = !lk0 && (bs >= hdr16);
    pl2      = take_len ? raw_fix : pl1;
    lk2      = lk0 || take_len;
    done     = lk2 && (bs >= pl2);
  end

  always_comb begin
    res        = '0;
    state_next = state_cur;
    case (op)
      OP_DATA: begin
        res.out_byte        = data_byte;
        res.byte_valid      = 1'b1;
        res.first_of_packet = start;
        res.last_of_packet  = done;
        res.length_error    = take_len && range_err;
        if (done) begin
          state_next = '0;
        end else begin
          state_next.bytes_seen      = bs;
          state_next.packet_length   = pl2;
          state_next.length_low_byte = llb1;
          state_next.length_known    = lk2;
        end
      end
      OP_FLUSH: begin
        res.last_of_packet = 1'b1;
        res.ended_by_flush = 1'b1;
        state_next         = '0;
      end
      OP_CLEAR: begin
        res.dropped_bytes = idx;
        state_next        = '0;
      end
      default: begin
        // Unused command: empty result, state kept.
      end
    endcase
  end

endmodule

`default_nettype wire

### rtl/core/lpd_checker.sv
// ----------------------------------------------------------------------------
// Deframer port checker
// Concurrent checks on the deframer ports, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "length_prefixed_packet_deframer_unit_macros.svh"

module lpd_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic [7:0]  out_byte,
  input wire logic        byte_valid,
  input wire logic        first_of_packet,
  input wire logic        last_of_packet,
  input wire logic        ended_by_flush,
  input wire logic        length_error,
  input wire logic [15:0] dropped_bytes
);

  // A stalled result stays in place.
  `LPD_ASSERT(a_out_hold, out_valid && !out_ready |=> out_valid && $stable(out_byte), "result dropped while stalled")

  // A flush result ends a packet and carries no byte.
  `LPD_ASSERT(a_flush_shape, out_valid && ended_by_flush |-> last_of_packet && !byte_valid, "malformed flush result")

  // A clear result reports only the dropped count.
  `LPD_ASSERT(a_clear_shape, out_valid && dropped_bytes != 16'd0 |-> !byte_valid && !last_of_packet && !first_of_packet, "malformed clear result")

  // A length error is only flagged on a header byte.
  `LPD_ASSERT(a_err_on_byte, out_valid && length_error |-> byte_valid && !ended_by_flush, "length error without a byte")

  // Reset empties the result register.
  `LPD_ASSERT_ALWAYS(a_reset_empty, rst |=> !out_valid, "result valid after reset")

endmodule

bind length_prefixed_packet_deframer_unit lpd_checker u_lpd_checker (
  .clk             (clk),
  .rst             (rst),
  .out_valid       (out_valid),
  .out_ready       (out_ready),
  .out_byte        (out_byte),
  .byte_valid      (byte_valid),
  .first_of_packet (first_of_packet),
  .last_of_packet  (last_of_packet),
  .ended_by_flush  (ended_by_flush),
  .length_error    (length_error),
  .dropped_bytes   (dropped_bytes)
);

`default_nettype wire

### test/length_prefixed_packet_deframer_unit_tb.sv
// ----------------------------------------------------------------------------
// Length-prefixed packet deframer testbench
// The testbench drives a byte stream, flushes and clears through the input
// channel. It checks every result transfer against its own deframer model,
// first with a short directed table and then with random packet traffic
// under changing header settings, with random stalls on both channels.
// ----------------------------------------------------------------------------
module length_prefixed_packet_deframer_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import lpd_pkg::*;

  // The input field is two bits wide. The package names three commands, and
  // the fourth code is accepted by the block and answered with an all-zero
  // result that leaves the tracking state alone.
  localparam logic [1:0] OP_UNUSED = 2'd3;

  localparam int MAX_PACKET = MAX_PACKET_BYTES_DEFAULT;
  localparam int RANDOM_ITEMS = 900;
  localparam int QUIET_ITEMS = 80;
  localparam int PHASE_ITEMS = 110;
  localparam int HOLD_OFF_CYCLES = 400;
  localparam int HOLD_OFF_AFTER = 150;
  localparam int DRAIN_CYCLES = 10;
  localparam int STALL_LIMIT = 4000;

  // One row of the directed table. A row either writes one register or
  // offers one input transfer. Where the expected result can be stated
  // outright, it is carried in the row; otherwise the model supplies it.
  typedef struct packed {
    logic        is_cfg;
    logic        cfg_idx;
    logic [6:0]  cfg_value;
    logic [1:0]  op;
    logic [7:0]  data;
    logic        has_fixed;
    result_t     want;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic       cfg_write = 1'b0;
  logic       cfg_index = 1'b0;
  logic [6:0] cfg_data = '0;

  logic       in_valid = 1'b0;
  logic       in_ready;
  logic [1:0] in_op = OP_DATA;
  logic [7:0] in_data = '0;

  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [7:0]  out_byte;
  logic        byte_valid;
  logic        first_of_packet;
  logic        last_of_packet;
  logic        ended_by_flush;
  logic        length_error;
  logic [15:0] dropped_bytes;

  // Model copy of the configuration and of the packet tracking state.
  logic [6:0] cfg_header_bytes = HEADER_BYTES_RESET;
  logic [5:0] cfg_length_offset = LENGTH_OFFSET_RESET;
  state_t     track = '0;

  // Results the block owes us, oldest first.
  result_t pending_results[$];
  stim_row_t directed_rows[$];

  int  error_count = 0;
  int  items_sent = 0;
  int  results_seen = 0;
  int  stall_cycles = 0;
  // Set for the tail of the run: from then on neither side idles.
  bit  quiet = 1'b0;

  length_prefixed_packet_deframer_unit u_top (
    .clk             (clk),
    .rst             (rst),
    .cfg_write       (cfg_write),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .op              (in_op),
    .data_byte       (in_data),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_byte        (out_byte),
    .byte_valid      (byte_valid),
    .first_of_packet (first_of_packet),
    .last_of_packet  (last_of_packet),
    .ended_by_flush  (ended_by_flush),
    .length_error    (length_error),
    .dropped_bytes   (dropped_bytes)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // --------------------------------------------------------------------------
  // Deframer model
  // --------------------------------------------------------------------------

  // The header size register holds seven bits, but the block works with it
  // saturated into the supported range.
  function automatic int effective_header();
    int h;
    h = cfg_header_bytes;
    if (h < HEADER_BYTES_MIN) h = HEADER_BYTES_MIN;
    if (h > HEADER_BYTES_MAX) h = HEADER_BYTES_MAX;
    return h;
  endfunction

  // Works out the result of one input transfer and advances the tracking
  // state exactly as the block must.
  function automatic result_t predict_deframe(input logic [1:0] o, input logic [7:0] d);
    result_t r;
    int hdr;
    int off;
    int idx;
    int raw;
    r = '0;
    hdr = effective_header();
    off = cfg_length_offset;
    idx = track.bytes_seen;
    case (o)
      OP_FLUSH: begin
        // A flush always closes a packet, even an empty one.
        r.last_of_packet = 1'b1;
        r.ended_by_flush = 1'b1;
        track = '0;
      end
      OP_CLEAR: begin
        r.dropped_bytes = track.bytes_seen;
        track = '0;
      end
      OP_DATA: begin
        r.out_byte = d;
        r.byte_valid = 1'b1;
        if (idx == 0) begin
          r.first_of_packet = 1'b1;
          track = '0;
        end
        // Capture the little-endian length while the header is still open.
        if (!track.length_known) begin
          if (idx == off) begin
            track.length_low_byte = d;
          end else if (idx == off + 1) begin
            track.packet_length = {d, track.length_low_byte};
          end
        end
        track.bytes_seen = 16'(idx + 1);
        // The header closes as soon as the count reaches the header size,
        // which also covers a header that shrank while a packet was open.
        if (!track.length_known && track.bytes_seen >= hdr) begin
          // Length bytes that lie past the header read as zero.
          if (off + 1 < hdr) begin
            raw = track.packet_length;
          end else if (off < hdr) begin
            raw = track.length_low_byte;
          end else begin
            raw = 0;
          end
          if (raw < hdr) begin
            raw = hdr;
            r.length_error = 1'b1;
          end else if (raw > MAX_PACKET) begin
            raw = MAX_PACKET;
            r.length_error = 1'b1;
          end
          track.packet_length = 16'(raw);
          track.length_known = 1'b1;
        end
        if (track.length_known && track.bytes_seen >= track.packet_length) begin
          r.last_of_packet = 1'b1;
          track = '0;
        end
      end
      default: begin
      end
    endcase
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // Input side
  // --------------------------------------------------------------------------

  // Offers one transfer and holds it until the block takes it. On the edge
  // of the transfer the expected result is queued: either the one given by
  // the caller or the model's. Now and then the sender then pauses.
  task automatic send_item(input logic [1:0] o, input logic [7:0] d,
                           input logic has_fixed, input result_t fixed,
                           output result_t r);
    int gap;
    in_valid <= 1'b1;
    in_op <= o;
    in_data <= d;
    do @(posedge clk); while (!in_ready);
    r = predict_deframe(o, d);
    pending_results.push_back(has_fixed ? fixed : r);
    if (o != OP_UNUSED) items_sent++;
    if (!quiet && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 11);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Register writes happen only with the block idle. Every transfer yields
  // exactly one result, so an empty queue means nothing is in flight.
  task automatic write_register(input logic idx, input logic [6:0] value);
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(posedge clk);
    cfg_write <= 1'b0;
    if (idx == CFG_HEADER_BYTES) begin
      cfg_header_bytes = value;
    end else begin
      cfg_length_offset = value[5:0];
    end
    @(posedge clk);
  endtask

  // Sends a packet whose header carries the given length at the configured
  // offset, with random bytes elsewhere. It stops when the block should
  // mark the end of the packet or after cut bytes, whichever comes first.
  task automatic send_packet(input int length, input int cut);
    int off;
    logic [7:0] b;
    result_t r;
    off = cfg_length_offset;
    // A packet left open by a stray byte is closed first, so that the length
    // bytes land where the block looks for them.
    if (track.bytes_seen != 16'd0) begin
      send_item($urandom_range(0, 1) ? OP_FLUSH : OP_CLEAR, 8'($urandom_range(0, 255)),
                1'b0, '0, r);
    end
    for (int i = 0; i < cut; i++) begin
      b = 8'($urandom_range(0, 255));
      if (i == off) begin
        b = length[7:0];
      end else if (i == off + 1) begin
        b = length[15:8];
      end
      send_item(OP_DATA, b, 1'b0, '0, r);
      if (r.last_of_packet) break;
    end
  endtask

  // Closes whatever is open with either a flush or a clear.
  task automatic send_terminator();
    result_t r;
    send_item($urandom_range(0, 1) ? OP_FLUSH : OP_CLEAR, 8'($urandom_range(0, 255)),
              1'b0, '0, r);
  endtask

  function automatic stim_row_t item_row(input logic [1:0] o, input logic [7:0] d);
    stim_row_t s;
    s = '0;
    s.op = o;
    s.data = d;
    return s;
  endfunction

  function automatic stim_row_t fixed_row(input logic [1:0] o, input logic [7:0] d,
                                          input result_t want);
    stim_row_t s;
    s = item_row(o, d);
    s.has_fixed = 1'b1;
    s.want = want;
    return s;
  endfunction

  function automatic stim_row_t cfg_row(input logic idx, input logic [6:0] value);
    stim_row_t s;
    s = '0;
    s.is_cfg = 1'b1;
    s.cfg_idx = idx;
    s.cfg_value = value;
    return s;
  endfunction

  // --------------------------------------------------------------------------
  // Result side
  // --------------------------------------------------------------------------

  // The receiver is mostly ready, idles in short random bursts, and once in
  // the run holds off long enough for the block to fill and stall its input
  // while the sender keeps offering transfers.
  initial begin : receiver
    bit held_off;
    int burst;
    held_off = 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (!quiet && !held_off && results_seen >= HOLD_OFF_AFTER) begin
        held_off = 1'b1;
        out_ready <= 1'b0;
        repeat (HOLD_OFF_CYCLES) @(posedge clk);
      end else if (!quiet && $urandom_range(0, 9) == 0) begin
        burst = $urandom_range(1, 11);
        out_ready <= 1'b0;
        repeat (burst) @(posedge clk);
      end else begin
        out_ready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  task automatic compare_field(input string name, input int unsigned want,
                               input int unsigned got);
    if (want != got) begin
      $display("%0t: %s mismatch: expected %0d, actual %0d", $realtime, name, want, got);
      error_count++;
    end
  endtask

  // Every result transfer is matched against the oldest expectation.
  always @(posedge clk) begin
    result_t want;
    if (!rst && out_valid && out_ready) begin
      results_seen++;
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result: expected none, actual byte %0d dropped %0d",
                 $realtime, out_byte, dropped_bytes);
        error_count++;
      end else begin
        want = pending_results.pop_front();
        compare_field("out_byte", want.out_byte, out_byte);
        compare_field("byte_valid", want.byte_valid, byte_valid);
        compare_field("first_of_packet", want.first_of_packet, first_of_packet);
        compare_field("last_of_packet", want.last_of_packet, last_of_packet);
        compare_field("ended_by_flush", want.ended_by_flush, ended_by_flush);
        compare_field("length_error", want.length_error, length_error);
        compare_field("dropped_bytes", want.dropped_bytes, dropped_bytes);
      end
    end
  end

  // The watchdog counts cycles in which neither channel moves a transfer.
  initial begin : watchdog
    while (stall_cycles < STALL_LIMIT) begin
      @(posedge clk);
      if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
        stall_cycles = 0;
      end else begin
        stall_cycles++;
      end
    end
    $display("FAILURE");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin : stimulus
    result_t r;
    stim_row_t row;
    int phase;
    int random_start;
    int random_items;
    int phase_end;
    int hdr;
    int off;
    int kind;
    logic [6:0] hdr_value;

    // Directed table. Defaults after reset are a four-byte header with the
    // length field at offset zero. The result fields are listed as out_byte,
    // byte_valid, first, last, flush, length_error, dropped_bytes.
    // A flush with nothing open still reports an empty packet end.
    directed_rows.push_back(fixed_row(OP_FLUSH, 8'h00,
                                      {8'h00, 1'b0, 1'b0, 1'b1, 1'b1, 1'b0, 16'd0}));
    // A clear with nothing open drops zero bytes.
    directed_rows.push_back(fixed_row(OP_CLEAR, 8'hFF,
                                      {8'h00, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 16'd0}));
    // The unused code yields an all-zero result.
    directed_rows.push_back(fixed_row(OP_UNUSED, 8'hFF,
                                      {8'h00, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 16'd0}));
    // A well-formed five-byte packet.
    directed_rows.push_back(fixed_row(OP_DATA, 8'h05,
                                      {8'h05, 1'b1, 1'b1, 1'b0, 1'b0, 1'b0, 16'd0}));
    directed_rows.push_back(item_row(OP_DATA, 8'h00));
    directed_rows.push_back(item_row(OP_DATA, 8'hFF));
    directed_rows.push_back(item_row(OP_DATA, 8'hAA));
    directed_rows.push_back(item_row(OP_DATA, 8'h55));
    // A declared length of zero is raised to the header size and flagged on
    // the byte that closes the header, which then also ends the packet.
    directed_rows.push_back(item_row(OP_DATA, 8'h00));
    directed_rows.push_back(item_row(OP_DATA, 8'h00));
    directed_rows.push_back(item_row(OP_DATA, 8'h11));
    directed_rows.push_back(fixed_row(OP_DATA, 8'h22,
                                      {8'h22, 1'b1, 1'b0, 1'b1, 1'b0, 1'b1, 16'd0}));
    // A flush ends a partial packet.
    directed_rows.push_back(item_row(OP_DATA, 8'h80));
    directed_rows.push_back(fixed_row(OP_FLUSH, 8'h7F,
                                      {8'h00, 1'b0, 1'b0, 1'b1, 1'b1, 1'b0, 16'd0}));
    // Smallest header with the length field straddling its end: only the
    // low byte counts.
    directed_rows.push_back(cfg_row(CFG_HEADER_BYTES, HEADER_BYTES_MIN));
    directed_rows.push_back(cfg_row(CFG_LENGTH_OFFSET, 7'd1));
    directed_rows.push_back(item_row(OP_DATA, 8'h00));
    directed_rows.push_back(item_row(OP_DATA, 8'h03));
    directed_rows.push_back(item_row(OP_DATA, 8'h7F));
    // A header size below the range saturates, and a length field entirely
    // outside the header reads as zero.
    directed_rows.push_back(cfg_row(CFG_HEADER_BYTES, 7'd0));
    directed_rows.push_back(cfg_row(CFG_LENGTH_OFFSET, 7'd63));
    directed_rows.push_back(item_row(OP_DATA, 8'h01));
    directed_rows.push_back(item_row(OP_DATA, 8'h02));
    // The header shrinks while a packet is open: the length is taken on the
    // next byte, since the count has already reached the new header size.
    directed_rows.push_back(cfg_row(CFG_HEADER_BYTES, 7'd8));
    directed_rows.push_back(cfg_row(CFG_LENGTH_OFFSET, 7'd0));
    directed_rows.push_back(item_row(OP_DATA, 8'h10));
    directed_rows.push_back(item_row(OP_DATA, 8'h00));
    directed_rows.push_back(item_row(OP_DATA, 8'h33));
    directed_rows.push_back(cfg_row(CFG_HEADER_BYTES, 7'd3));
    directed_rows.push_back(item_row(OP_DATA, 8'h44));
    directed_rows.push_back(item_row(OP_DATA, 8'h5A));
    // A clear reports the five bytes it drops.
    directed_rows.push_back(fixed_row(OP_CLEAR, 8'h00,
                                      {8'h00, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 16'd5}));

    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (directed_rows[i]) begin
      row = directed_rows[i];
      if (row.is_cfg) begin
        write_register(row.cfg_idx, row.cfg_value);
      end else begin
        send_item(row.op, row.data, row.has_fixed, row.want, r);
      end
    end

    // Random part. Each phase picks a header size and a length offset, with
    // the extremes in rotation, and then sends mostly well-formed packets,
    // with some malformed lengths, truncations and stray commands mixed in.
    phase = 0;
    random_start = items_sent;
    random_items = 0;
    while (random_items < RANDOM_ITEMS) begin
      case (phase % 8)
        0: hdr_value = 7'd127;
        1: hdr_value = HEADER_BYTES_MAX;
        2: hdr_value = HEADER_BYTES_MIN;
        3: hdr_value = 7'd0;
        4: hdr_value = 7'd1;
        5: hdr_value = 7'($urandom_range(3, 16));
        6: hdr_value = HEADER_BYTES_MAX;
        default: hdr_value = 7'($urandom_range(2, 12));
      endcase
      write_register(CFG_HEADER_BYTES, hdr_value);
      hdr = effective_header();
      case ($urandom_range(0, 5))
        0: off = 0;
        1: off = hdr - 2;
        2: off = hdr - 1;
        3: off = hdr;
        4: off = $urandom_range(62, 63);
        default: off = $urandom_range(0, hdr - 2);
      endcase
      if (off > 63) off = 63;
      // The top data bit is not part of the offset register.
      write_register(CFG_LENGTH_OFFSET, {$urandom_range(0, 1) ? 1'b1 : 1'b0, off[5:0]});

      phase_end = random_items + PHASE_ITEMS;
      while (random_items < phase_end && random_items < RANDOM_ITEMS) begin
        kind = $urandom_range(0, 19);
        if (kind <= 9 || kind == 19) begin
          send_packet(hdr + $urandom_range(0, 24), 65536);
        end else if (kind == 10) begin
          send_packet(hdr + $urandom_range(100, 400), 65536);
        end else if (kind <= 12) begin
          send_packet($urandom_range(0, hdr - 1), 65536);
        end else if (kind == 13) begin
          // Oversized or maximum lengths would run for thousands of bytes,
          // so these packets are cut short a little past the header.
          send_packet($urandom_range(0, 1) ? MAX_PACKET : $urandom_range(MAX_PACKET + 1, 65535),
                      hdr + $urandom_range(0, 30));
          send_terminator();
        end else if (kind == 14) begin
          send_item(OP_FLUSH, 8'($urandom_range(0, 255)), 1'b0, '0, r);
        end else if (kind == 15) begin
          send_item(OP_CLEAR, 8'($urandom_range(0, 255)), 1'b0, '0, r);
        end else if (kind == 16) begin
          send_item(OP_UNUSED, 8'($urandom_range(0, 255)), 1'b0, '0, r);
        end else if (kind == 17) begin
          send_item(OP_DATA, 8'($urandom_range(0, 255)), 1'b0, '0, r);
        end else begin
          send_packet($urandom_range(0, 65535), $urandom_range(1, hdr + 8));
          send_terminator();
        end
        random_items = items_sent - random_start;
        if (random_items >= RANDOM_ITEMS - QUIET_ITEMS) quiet = 1'b1;
      end
      phase++;
    end

    // Let every owed result arrive, then keep watching for any stray
    // transfer before the verdict.
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (error_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
